@@ rtl/kpgc_pkg.sv @@
// Package with shared types and constants of the key press gesture classifier.
`timescale 1ns / 1ps
`default_nettype none

package kpgc_pkg;

  // Field and counter widths
  localparam int unsigned LevelW    = 4;
  localparam int unsigned DebounceW = 8;
  localparam int unsigned HeldW     = 14;
  localparam int unsigned RelW      = 8;
  localparam int unsigned WinW      = 10;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 14;

  // Register values after reset
  localparam logic [DebounceW-1:0] DebounceReset = 8'd10;
  localparam logic [HeldW-1:0]     LongReset     = 14'd2000;
  localparam logic [WinW-1:0]      WindowReset   = 10'd300;

  // Register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_LONG     = 2'd1,
    CFG_WINDOW   = 2'd2
  } kpgc_cfg_idx_e;

  // Per-key press phase
  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_HELD      = 2'd1,
    PH_RELEASING = 2'd2
  } kpgc_phase_e;

  typedef struct packed {
    logic [DebounceW-1:0] debounce;
    logic [HeldW-1:0]     long_press;
    logic [WinW-1:0]      window;
  } kpgc_cfg_t;

  typedef struct packed {
    logic short_ev;
    logic long_ev;
    logic double_ev;
  } kpgc_events_t;

endpackage

`default_nettype wire

@@ rtl/kpgc_key.sv @@
// One key's debounce and gesture state machine with its counters.
`timescale 1ns / 1ps
`default_nettype none

module kpgc_key (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                advance_i,
  input  wire logic                pressed_i,
  input  wire kpgc_pkg::kpgc_cfg_t cfg_i,
  output kpgc_pkg::kpgc_events_t   events_o
);
  import kpgc_pkg::*;

  kpgc_phase_e      phase_q, phase_d;
  logic [HeldW-1:0] held_q, held_d, held_inc;
  logic [RelW-1:0]  rel_q, rel_d, rel_inc;
  logic             armed_q, armed_d, armed_mid;
  logic [WinW-1:0]  win_q, win_d, win_mid, win_inc;
  logic             rel_done, long_hit, win_hit;

  // Saturating increments
  assign held_inc = (held_q == '1) ? held_q : held_q + 1'b1;
  assign rel_inc  = (rel_q == '1) ? rel_q : rel_q + 1'b1;

  assign rel_done = (phase_q == PH_RELEASING) && !pressed_i && (rel_inc >= cfg_i.debounce);
  assign long_hit = (held_q >= cfg_i.long_press);

  // Press completion moves the double-click window before it ticks
  always_comb begin
    armed_mid = armed_q;
    win_mid   = win_q;
    if (rel_done && !long_hit) begin
      if (!armed_q) begin
        armed_mid = 1'b1;
        win_mid   = '0;
      end else begin
        armed_mid = 1'b0;
      end
    end
  end

  assign win_inc = (win_mid == '1) ? win_mid : win_mid + 1'b1;
  assign win_hit = armed_mid && (win_inc >= cfg_i.window);

  // Next state
  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    rel_d   = rel_q;
    unique case (phase_q)
      PH_HELD: begin
        if (pressed_i) begin
          held_d = held_inc;
        end else begin
          phase_d = PH_RELEASING;
          rel_d   = rel_inc;
        end
      end
      PH_RELEASING: begin
        if (!pressed_i) begin
          rel_d = rel_inc;
          if (rel_done) begin
            phase_d = PH_IDLE;
            held_d  = '0;
            rel_d   = '0;
          end
        end
      end
      default: begin
        if (pressed_i) begin
          held_d = held_inc;
          if ({{(HeldW-DebounceW){1'b0}}, cfg_i.debounce} <= held_inc) begin
            phase_d = PH_HELD;
          end
        end
      end
    endcase

    armed_d = armed_mid;
    win_d   = win_mid;
    if (armed_mid) begin
      win_d = win_inc;
      if (win_hit) begin
        win_d   = '0;
        armed_d = 1'b0;
      end
    end
  end

  // Event outputs
  always_comb begin
    events_o.long_ev   = rel_done && long_hit;
    events_o.double_ev = rel_done && !long_hit && armed_q;
    events_o.short_ev  = win_hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      held_q  <= '0;
      rel_q   <= '0;
      armed_q <= 1'b0;
      win_q   <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      rel_q   <= rel_d;
      armed_q <= armed_d;
      win_q   <= win_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/key_press_gesture_classifier.sv @@
// Top level of the key press gesture classifier: configuration, key array, result register.
// The result of an accepted item is registered and appears in the cycle after acceptance.
// Throughput: one item per cycle; the per-key counters and compares finish in one pass.
// The single result register sets the pace: input stalls only while it holds an untaken item.
// Reset: key state clears to idle with zero counters, no result pending, and the
// registers return to debounce 10, long press 2000 and double window 300 ticks.
`timescale 1ns / 1ps
`default_nettype none

module key_press_gesture_classifier #(
  parameter int unsigned NUM_KEYS = 4
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // tick items
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [kpgc_pkg::LevelW-1:0]      key_levels_i,
  // result items
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [kpgc_pkg::LevelW-1:0]           short_events_o,
  output logic [kpgc_pkg::LevelW-1:0]           long_events_o,
  output logic [kpgc_pkg::LevelW-1:0]           double_events_o,
  // register writes
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [kpgc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [kpgc_pkg::CfgDataW-1:0]    cfg_data_i
);
  import kpgc_pkg::*;

  // Only the first four keys have a level on the port; further keys see released.
  localparam int unsigned OutKeys = (NUM_KEYS < LevelW) ? NUM_KEYS : LevelW;

  kpgc_cfg_t          cfg_q;
  logic               accept;
  logic               out_valid_q, out_valid_d;
  logic [LevelW-1:0]  short_q, long_q, double_q;
  logic [LevelW-1:0]  short_d, long_d, double_d;
  kpgc_events_t       key_ev [NUM_KEYS];

  // Registers take writes at any time; the user writes them only while idle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce   <= DebounceReset;
      cfg_q.long_press <= LongReset;
      cfg_q.window     <= WindowReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_DEBOUNCE: cfg_q.debounce   <= cfg_data_i[DebounceW-1:0];
        CFG_LONG:     cfg_q.long_press <= cfg_data_i[HeldW-1:0];
        CFG_WINDOW:   cfg_q.window     <= cfg_data_i[WinW-1:0];
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  // Stall input only while the result register is full and its item is not taken.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // One state machine per key, advancing on every accepted tick
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    logic pressed;
    if (k < LevelW) begin : g_port
      assign pressed = key_levels_i[k];
    end else begin : g_none
      assign pressed = 1'b0;
    end

    kpgc_key u_key (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (accept),
      .pressed_i (pressed),
      .cfg_i     (cfg_q),
      .events_o  (key_ev[k])
    );
  end

  // Gather event bits of the keys that reach the output fields
  always_comb begin
    short_d  = '0;
    long_d   = '0;
    double_d = '0;
    for (int unsigned k = 0; k < OutKeys; k++) begin
      short_d[k]  = key_ev[k].short_ev;
      long_d[k]   = key_ev[k].long_ev;
      double_d[k] = key_ev[k].double_ev;
    end
  end

  // Result register: load on accept, empty once taken, hold while stalled
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      short_q  <= short_d;
      long_q   <= long_d;
      double_q <= double_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign short_events_o  = short_q;
  assign long_events_o   = long_q;
  assign double_events_o = double_q;

  // Every accepted tick leaves a result item behind
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> out_valid_o)
    else $error("accepted item produced no result");

  // Input stalls only behind a pending result
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> out_valid_o)
    else $error("input stalled with empty result register");

  // A finished press is either long or double, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((long_events_o & double_events_o) == '0))
    else $error("long and double event on the same key");

  // A double click disarms the window, so it cannot also expire
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((short_events_o & double_events_o) == '0))
    else $error("short and double event on the same key");

endmodule

`default_nettype wire

@@ tb/key_press_gesture_classifier_tb.sv @@
// Self-checking testbench for the key press gesture classifier, with its own predictor.
`timescale 1ns / 1ps

module key_press_gesture_classifier_tb;
  import kpgc_pkg::*;

  localparam int unsigned Keys       = LevelW;
  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned MaxReports = 10;

  // One result item: one event mask per gesture kind
  typedef struct packed {
    logic [LevelW-1:0] short_keys;
    logic [LevelW-1:0] long_keys;
    logic [LevelW-1:0] double_keys;
  } gesture_t;

  // Block inputs start at known values; reset is held from time zero
  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic [LevelW-1:0]   key_levels_i = '0;
  logic                out_stall_i  = 1'b0;
  logic                cfg_valid_i  = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i   = '0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic [LevelW-1:0]   short_events_o;
  logic [LevelW-1:0]   long_events_o;
  logic [LevelW-1:0]   double_events_o;
  logic                cfg_ready_o;

  key_press_gesture_classifier DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .key_levels_i   (key_levels_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .short_events_o (short_events_o),
    .long_events_o  (long_events_o),
    .double_events_o(double_events_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Predictor copy of the timing registers
  logic [DebounceW-1:0] debounce_r;
  logic [HeldW-1:0]     long_r;
  logic [WinW-1:0]      window_r;

  // Predictor copy of the per-key state
  kpgc_phase_e      key_phase     [Keys];
  logic [HeldW-1:0] held_cnt      [Keys];
  logic [RelW-1:0]  released_cnt  [Keys];
  logic             window_armed  [Keys];
  logic [WinW-1:0]  window_cnt    [Keys];

  // Pending tick items and the gestures they are due to produce
  logic [LevelW-1:0] tick_queue [$];
  gesture_t          gesture_q  [$];

  // Per-key run generator: current level and ticks left in the run
  logic        run_level [Keys];
  int unsigned run_left  [Keys];

  bit          calm_phase;
  int unsigned send_pause;
  int unsigned stall_left;
  int unsigned cycle_count;
  int unsigned fault_count;
  int unsigned ticks_sent;
  int unsigned results_checked;
  int unsigned shorts_seen;
  int unsigned longs_seen;
  int unsigned doubles_seen;
  int unsigned settings_used;
  gesture_t    due;
  gesture_t    seen;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Advance every key by one tick and return the events it raises.
  // Saturate all counters; a pressed level while releasing is ignored,
  // and a released level in idle leaves the held count alone.
  function automatic gesture_t classify_tick(input logic [LevelW-1:0] levels);
    gesture_t ev;
    ev = '0;
    for (int k = 0; k < Keys; k++) begin
      case (key_phase[k])
        PH_HELD: begin
          if (levels[k]) begin
            if (held_cnt[k] != '1) held_cnt[k]++;
          end else begin
            key_phase[k] = PH_RELEASING;
            if (released_cnt[k] != '1) released_cnt[k]++;
          end
        end
        PH_RELEASING: begin
          if (!levels[k]) begin
            if (released_cnt[k] != '1) released_cnt[k]++;
            if (released_cnt[k] >= debounce_r) begin
              if (held_cnt[k] >= long_r) begin
                ev.long_keys[k] = 1'b1;
              end else if (!window_armed[k]) begin
                window_armed[k] = 1'b1;
                window_cnt[k]   = '0;
              end else begin
                ev.double_keys[k] = 1'b1;
                window_armed[k]   = 1'b0;
              end
              key_phase[k]    = PH_IDLE;
              held_cnt[k]     = '0;
              released_cnt[k] = '0;
            end
          end
        end
        default: begin
          if (levels[k]) begin
            if (held_cnt[k] != '1) held_cnt[k]++;
            if (held_cnt[k] >= debounce_r) key_phase[k] = PH_HELD;
          end
        end
      endcase
      // The window runs in the same tick that armed it
      if (window_armed[k]) begin
        if (window_cnt[k] != '1) window_cnt[k]++;
        if (window_cnt[k] >= window_r) begin
          window_cnt[k]     = '0;
          window_armed[k]   = 1'b0;
          ev.short_keys[k]  = 1'b1;
        end
      end
    end
    return ev;
  endfunction

  // Mostly no pause, sometimes a short one, now and then a long one
  function automatic int unsigned pick_pause();
    int unsigned roll;
    roll = $urandom_range(99);
    if (calm_phase || roll < 70) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Queue well-formed press and release runs per key, sized around the current
  // timing so that clicks, double clicks and long presses all complete; some
  // runs fall short of the debounce to act as bounce.
  task automatic queue_gestures(input int unsigned count);
    logic [LevelW-1:0] lv;
    int unsigned       roll;
    int unsigned       short_top;
    for (int unsigned i = 0; i < count; i++) begin
      for (int k = 0; k < Keys; k++) begin
        if (run_left[k] == 0) begin
          run_level[k] = !run_level[k];
          roll         = $urandom_range(99);
          short_top    = (long_r > 1) ? long_r - 1 : 1;
          if (roll < 15) begin
            run_left[k] = $urandom_range(1, debounce_r);
          end else if (run_level[k]) begin
            if (roll < 75) run_left[k] = $urandom_range(debounce_r, short_top);
            else run_left[k] = $urandom_range(long_r, long_r + 6);
          end else begin
            if (roll < 70) run_left[k] = $urandom_range(debounce_r, debounce_r + window_r);
            else run_left[k] = $urandom_range(debounce_r + window_r,
                                              debounce_r + 2 * window_r + 4);
          end
          if (run_left[k] == 0) run_left[k] = 1;
        end
        lv[k] = run_level[k];
        run_left[k]--;
      end
      tick_queue.push_back(lv);
    end
  endtask

  // Write one register and mirror it, masked to its width, in the predictor
  task automatic write_reg(input kpgc_cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_DEBOUNCE: debounce_r = value[DebounceW-1:0];
      CFG_LONG:     long_r     = value[HeldW-1:0];
      default:      window_r   = value[WinW-1:0];
    endcase
  endtask

  task automatic program_timing(input logic [CfgDataW-1:0] deb, lng, win);
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_LONG, lng);
    write_reg(CFG_WINDOW, win);
    for (int k = 0; k < Keys; k++) run_left[k] = 0;
    settings_used++;
    @(negedge clk_i);
  endtask

  // Hold the sender until every queued tick has gone in and every gesture is back
  task automatic wait_for_drain();
    do @(negedge clk_i);
    while (tick_queue.size() != 0 || in_valid_i || gesture_q.size() != 0);
    repeat (2) @(negedge clk_i);
  endtask

  // Sender: hold an item while stalled, predict on acceptance, then pause at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_pause <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        gesture_q.push_back(classify_tick(key_levels_i));
        ticks_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_pause > 0) begin
          in_valid_i <= 1'b0;
          send_pause <= send_pause - 1;
        end else if (tick_queue.size() > 0) begin
          in_valid_i   <= 1'b1;
          key_levels_i <= tick_queue.pop_front();
          send_pause   <= pick_pause();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure: runs of stall with gaps in between
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      stall_left  <= pick_pause();
    end
  end

  // Checker: match each accepted result against the oldest due gesture
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = {short_events_o, long_events_o, double_events_o};
      if (gesture_q.size() == 0) begin
        if (fault_count < MaxReports)
          $display("%0t: result with nothing due: short %h long %h double %h",
                   $time, seen.short_keys, seen.long_keys, seen.double_keys);
        fault_count++;
      end else begin
        due = gesture_q.pop_front();
        results_checked++;
        shorts_seen  += $countones(due.short_keys);
        longs_seen   += $countones(due.long_keys);
        doubles_seen += $countones(due.double_keys);
        if (seen.short_keys !== due.short_keys || seen.long_keys !== due.long_keys ||
            seen.double_keys !== due.double_keys) begin
          if (fault_count < MaxReports)
            $display("%0t: result %0d: short %h/%h long %h/%h double %h/%h (due/got)",
                     $time, results_checked, due.short_keys, seen.short_keys,
                     due.long_keys, seen.long_keys, due.double_keys, seen.double_keys);
          fault_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("key_press_gesture_classifier_tb: errors");
      $finish;
    end
  end

  initial begin : stimulus
    logic [25*LevelW-1:0] script;
    logic [LevelW-1:0]    lv;
    // Initialise the predictor to the reset state
    debounce_r = DebounceReset;
    long_r     = LongReset;
    window_r   = WindowReset;
    for (int k = 0; k < Keys; k++) begin
      key_phase[k]    = PH_IDLE;
      held_cnt[k]     = '0;
      released_cnt[k] = '0;
      window_armed[k] = 1'b0;
      window_cnt[k]   = '0;
      run_level[k]    = 1'b0;
      run_left[k]     = 0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset timing: far too slow for any gesture in a few ticks, so check for silence
    queue_gestures(30);
    wait_for_drain();

    // Directed: all keys click at once, then a double click on key 0, a long
    // press on key 1, a press on key 3 while it is releasing, a lone short on key 2
    program_timing(1, 4, 6);
    script = 100'h0F00100322208080040000000;
    for (int i = 0; i < 25; i++) tick_queue.push_back(script[99 - 4 * i -: 4]);
    wait_for_drain();

    // Minimum non-zero timing
    program_timing(1, 1, 1);
    queue_gestures(70);
    wait_for_drain();

    // Back-to-back items with no idling on either side
    program_timing(2, 6, 8);
    calm_phase = 1'b1;
    queue_gestures(80);
    wait_for_drain();
    calm_phase = 1'b0;

    program_timing(3, 12, 20);
    queue_gestures(80);
    wait_for_drain();

    program_timing(4, 20, 30);
    queue_gestures(80);
    wait_for_drain();

    // All registers zero: every compare is true at once
    program_timing(0, 0, 0);
    queue_gestures(50);
    wait_for_drain();

    // All ones on the data port: masked to the top of each register. Random
    // bounce on every key stays far below the debounce, so nothing completes.
    program_timing('1, '1, '1);
    for (int n = 0; n < 40; n++) begin
      lv = LevelW'($urandom_range(15));
      tick_queue.push_back(lv);
    end
    wait_for_drain();

    repeat (2) begin
      program_timing(CfgDataW'($urandom_range(1, 6)), CfgDataW'($urandom_range(1, 30)),
                     CfgDataW'($urandom_range(1, 40)));
      queue_gestures(50);
      wait_for_drain();
    end

    repeat (5) @(negedge clk_i);
    if (gesture_q.size() != 0) begin
      $display("%0d results never arrived", gesture_q.size());
      fault_count++;
    end

    $display("%0d tick items over %0d timing settings, %0d results checked",
             ticks_sent, settings_used, results_checked);
    $display("gestures seen: %0d short, %0d long, %0d double; %0d mismatches",
             shorts_seen, longs_seen, doubles_seen, fault_count);
    if (fault_count == 0) begin
      $display("key_press_gesture_classifier_tb: clean");
    end else begin
      $display("key_press_gesture_classifier_tb: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/kpgc_pkg.sv
rtl/kpgc_key.sv
rtl/key_press_gesture_classifier.sv
tb/key_press_gesture_classifier_tb.sv
